// ===== rtl/urs_pkg.sv =====
// ----------------------------------------------------------------------------
// urs_pkg: shared types and constants of the update retransmit scheduler
// Request, configuration and result types, codes and the lowest-id encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package urs_pkg;

	localparam int MAX_IDS = 32;
	localparam int ID_W    = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

	localparam logic [15:0] RESET_TIMEOUT_MS  = 16'd500;
	localparam logic [7:0]  RESET_MAX_RETRIES = 8'd5;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_PUSH = 2'd1,
		MODE_ACK  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		EV_SET_INPUT  = 2'd0,
		EV_VAR_UPDATE = 2'd1,
		EV_DROPPED    = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT_MS    = 2'd0,
		REG_MAX_RETRIES   = 2'd1,
		REG_WIDGET_COUNT  = 2'd2,
		REG_INPUT_MASK    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [7:0]  max_retries;
		logic [5:0]  widget_count;
		logic [31:0] input_widget_mask;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  widget_id;
		logic [7:0]  ack_seq;
		logic        ack_has_payload;
		logic [31:0] now_ms;
		logic        connected;
	} item_t;

	typedef struct packed {
		event_t      event_res;
		logic [4:0]  target_id;
		logic [7:0]  sequence_res;
		logic [7:0]  attempt;
	} result_t;

	function automatic logic [ID_W-1:0] lowest_set(input logic [MAX_IDS-1:0] mask);
		logic [ID_W-1:0] idx;
		idx = '0;
		for (int i = MAX_IDS - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = ID_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/urs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// urs_cfg_regs: configuration registers
// Write-only register file for timeout, retry limit, widget count and mask.
// ----------------------------------------------------------------------------
`default_nettype none

module urs_cfg_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_wdata,
	output urs_pkg::cfg_t           cfg
);
	import urs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms        <= RESET_TIMEOUT_MS;
			cfg_q.max_retries       <= RESET_MAX_RETRIES;
			cfg_q.widget_count      <= '0;
			cfg_q.input_widget_mask <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TIMEOUT_MS:   cfg_q.timeout_ms        <= cfg_wdata[15:0];
				REG_MAX_RETRIES:  cfg_q.max_retries       <= cfg_wdata[7:0];
				REG_WIDGET_COUNT: cfg_q.widget_count      <= cfg_wdata[5:0];
				REG_INPUT_MASK:   cfg_q.input_widget_mask <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/urs_core.sv =====
// ----------------------------------------------------------------------------
// urs_core: scheduler state and combinational update
// Pending mask, current id, sequence, retry count and send time; one request
// per cycle while go is high, with at most one send or drop event on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module urs_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire urs_pkg::item_t     item,
	input  wire urs_pkg::cfg_t      cfg,
	output logic                    res_valid,
	output urs_pkg::result_t        res
);
	import urs_pkg::*;

	logic [MAX_IDS-1:0] pending_q, pending_n;
	logic [ID_W-1:0]    cur_q, cur_n;
	logic [7:0]         seq_q, seq_n;
	logic [7:0]         retry_q, retry_n;
	logic [31:0]        last_q, last_n;
	logic [31:0]        elapsed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			cur_q     <= '0;
			seq_q     <= '0;
			retry_q   <= '0;
			last_q    <= '0;
		end else if (go) begin
			pending_q <= pending_n;
			cur_q     <= cur_n;
			seq_q     <= seq_n;
			retry_q   <= retry_n;
			last_q    <= last_n;
		end
	end

	always_comb begin
		pending_n = pending_q;
		cur_n     = cur_q;
		seq_n     = seq_q;
		retry_n   = retry_q;
		last_n    = last_q;
		elapsed   = '0;
		res_valid = 1'b0;
		res       = '{event_res: EV_VAR_UPDATE, target_id: '0, sequence_res: '0,
			attempt: '0};
		unique case (item.mode)
			MODE_PUSH: begin
				if ({2'b00, item.widget_id} < {2'b00, cfg.widget_count, 2'b00} >> 2
						&& {1'b0, item.widget_id} < 9'(MAX_IDS)) begin
					pending_n[item.widget_id[ID_W-1:0]] = 1'b1;
				end
			end
			MODE_ACK: begin
				if (pending_q != '0 && item.ack_has_payload && item.ack_seq == seq_q) begin
					pending_n[cur_q] = 1'b0;
					retry_n = '0;
				end
			end
			MODE_TICK: begin
				if (item.connected && pending_q != '0) begin
					if (!pending_q[cur_q]) begin
						cur_n   = lowest_set(pending_q);
						seq_n   = seq_q + 8'd1;
						retry_n = '0;
						last_n  = '0;
					end
					elapsed = item.now_ms - last_n;
					if (last_n == '0 || elapsed >= {16'd0, cfg.timeout_ms}) begin
						res_valid        = 1'b1;
						res.target_id    = 5'(cur_n);
						res.sequence_res = seq_n;
						res.attempt      = retry_n;
						if (retry_n >= cfg.max_retries) begin
							res.event_res    = EV_DROPPED;
							pending_n[cur_n] = 1'b0;
							retry_n          = '0;
						end else begin
							res.event_res = cfg.input_widget_mask[5'(cur_n)] ?
								EV_SET_INPUT : EV_VAR_UPDATE;
							last_n  = item.now_ms;
							retry_n = retry_n + 8'd1;
						end
					end
				end
			end
			MODE_NONE: ;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/update_retransmit_scheduler.sv =====
// ----------------------------------------------------------------------------
// update_retransmit_scheduler: stop-and-wait retransmit scheduler
// Tracks pending widget updates and issues send or drop events on ticks.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the result side keeps up, a rate set
// by the whole state update (lowest-id pick, timeout subtract and compare,
// retry check) being combinational in the core. A request is registered on
// acceptance; once the core takes it, its event, if any, is registered for the
// master side. Configuration must be written through the plain write port
// while no request is in flight; the block itself does not enforce this.
`default_nettype none

module update_retransmit_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// widget_id[7:0], ack_seq[15:8], ack_has_payload[16], now_ms[48:17],
	// connected[49], zero pad[55:50]
	input  wire logic [55:0] s_tdata,
	// mode[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// target_id[4:0], sequence_res[12:5], attempt[20:13], zero pad[23:21]
	output logic [23:0]      m_tdata,
	// event_res[1:0]
	output logic [1:0]       m_tuser
);
	import urs_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    go;
	logic    res_valid;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	urs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign go       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode            <= mode_t'(s_tuser);
			item_s1.widget_id       <= s_tdata[7:0];
			item_s1.ack_seq         <= s_tdata[15:8];
			item_s1.ack_has_payload <= s_tdata[16];
			item_s1.now_ms          <= s_tdata[48:17];
			item_s1.connected       <= s_tdata[49];
		end
	end

	urs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.attempt, out_q.sequence_res, out_q.target_id};
	assign m_tuser  = out_q.event_res;

endmodule

`default_nettype wire
